@@ design/assert_macros.svh @@
// assertion macros shared by the touch calibration rtl
// no dependencies; define ASSERT_OFF to drop every check
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property checked on every clk_i edge outside reset
`define TSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition that must never be true outside reset
`define TSC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define TSC_ASSERT(lbl, prop, msg)
`define TSC_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

@@ design/tsc_pkg.sv @@
// types, constants and helpers for the touch calibration datapath
// no dependencies
`default_nettype none

package tsc_pkg;

  localparam int SAMPLE_W    = 12;
  localparam int SUM_W       = 12;
  localparam int GAIN_W      = 18;
  localparam int OFFS_W      = 27;
  localparam int PIX_W       = 9;
  localparam int FRAC_W      = 16;
  localparam int ACC_W       = 32;
  localparam int MIR_W       = 34;
  localparam int RECIP_SHIFT = 17;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 27;

  localparam logic signed [MIR_W-1:0] MIRROR_Q16   = 34'sd20971520; // 320.0
  localparam logic [PIX_W-1:0]        PIX_MAX      = 9'd511;
  localparam logic [PIX_W-1:0]        LAND_X_LIMIT = 9'd319;
  localparam logic [PIX_W-1:0]        JUMP_LIMIT   = 9'd3;
  localparam logic [PIX_W-1:0]        PIX_EDGE     = 9'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_X    = 3'd0,
    REG_OFFSET_X  = 3'd1,
    REG_GAIN_Y    = 3'd2,
    REG_OFFSET_Y  = 3'd3,
    REG_LANDSCAPE = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic signed [GAIN_W-1:0] gain_x;
    logic signed [OFFS_W-1:0] offset_x;
    logic signed [GAIN_W-1:0] gain_y;
    logic signed [OFFS_W-1:0] offset_y;
    logic                     landscape;
  } cfg_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum_x;
    logic [SUM_W-1:0] sum_y;
  } sums_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] acc_x;
    logic signed [ACC_W-1:0] acc_y;
    logic                    landscape;
  } scaled_t;

  // q16 to pixel: negative -> 0, truncate, clamp at 511
  function automatic logic [PIX_W-1:0] to_pixel(input logic signed [MIR_W-1:0] v);
    logic signed [MIR_W-1:0] ip;
    logic [PIX_W-1:0]        r;
    ip = v >>> FRAC_W;
    if (v[MIR_W-1]) begin
      r = '0;
    end else if (ip > 34'sd511) begin
      r = PIX_MAX;
    end else begin
      r = ip[PIX_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W-1:0] a,
                                                input logic [PIX_W-1:0] b);
    logic [PIX_W-1:0] r;
    r = (a > b) ? (a - b) : (b - a);
    return r;
  endfunction

endpackage

`default_nettype wire

@@ design/touch_sample_calibrate_core.sv @@
// top level of the resistive touch calibration block
// depends on tsc_pkg, tsc_accum, tsc_scale and tsc_map
`default_nettype none

// usage
//   input channel: in_valid_i / in_ready_o carry one pair of 12-bit adc
//   readings (x_sample_i, y_sample_i) per transfer; one pair is taken every
//   cycle while the path downstream keeps moving
//   every SAMPLES-th pair closes a group and yields one result on the output
//   channel out_valid_o / out_ready_i (coord_x_o, coord_y_o, jumped_o)
//   the transfer of the last pair of a group loads the input reg; the group
//   then moves through the sums reg, scale reg and result reg to the output
//   throughput: one pair per cycle unless stalled, set by the divide and
//   accumulate, done combinationally behind the input register
//   a stalled receiver holds the result register; the stages behind it keep
//   filling, and once the sums register is full the last pair of the next
//   group waits in the input register and in_ready_o drops
//   reset clears sums, pair count, previous point and every valid flag, and
//   loads the default calibration; cfg_we_i writes a register by cfg_idx_i
//   with no wait, unknown indexes are ignored; write only while idle

module touch_sample_calibrate_core #(
  parameter int SAMPLES = 4
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [tsc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [tsc_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [tsc_pkg::SAMPLE_W-1:0]    x_sample_i,
  input  wire logic [tsc_pkg::SAMPLE_W-1:0]    y_sample_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [tsc_pkg::PIX_W-1:0]            coord_x_o,
  output logic [tsc_pkg::PIX_W-1:0]            coord_y_o,
  output logic                                 jumped_o
);

  // power-on calibration
  localparam logic signed [tsc_pkg::GAIN_W-1:0] GAIN_X_RST   = 18'sd7668;
  localparam logic signed [tsc_pkg::OFFS_W-1:0] OFFSET_X_RST = 27'sd0;
  localparam logic signed [tsc_pkg::GAIN_W-1:0] GAIN_Y_RST   = -18'sd10224;
  localparam logic signed [tsc_pkg::OFFS_W-1:0] OFFSET_Y_RST = 27'sd20971520;

  tsc_pkg::cfg_t    cfg_q, cfg_d;
  logic             sum_valid, sum_ready;
  tsc_pkg::sums_t   sums;
  logic             sc_valid, sc_ready;
  tsc_pkg::scaled_t scaled;

  // configuration registers, excess data bits dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (tsc_pkg::cfg_reg_e'(cfg_idx_i))
        tsc_pkg::REG_GAIN_X:    cfg_d.gain_x    = cfg_wdata_i[tsc_pkg::GAIN_W-1:0];
        tsc_pkg::REG_OFFSET_X:  cfg_d.offset_x  = cfg_wdata_i[tsc_pkg::OFFS_W-1:0];
        tsc_pkg::REG_GAIN_Y:    cfg_d.gain_y    = cfg_wdata_i[tsc_pkg::GAIN_W-1:0];
        tsc_pkg::REG_OFFSET_Y:  cfg_d.offset_y  = cfg_wdata_i[tsc_pkg::OFFS_W-1:0];
        tsc_pkg::REG_LANDSCAPE: cfg_d.landscape = cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_x    <= GAIN_X_RST;
      cfg_q.offset_x  <= OFFSET_X_RST;
      cfg_q.gain_y    <= GAIN_Y_RST;
      cfg_q.offset_y  <= OFFSET_Y_RST;
      cfg_q.landscape <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // divide and accumulate, one pair per transfer
  tsc_accum #(
    .SAMPLES(SAMPLES)
  ) u_accum (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .x_sample_i (x_sample_i),
    .y_sample_i (y_sample_i),
    .sum_valid_o(sum_valid),
    .sum_ready_i(sum_ready),
    .sums_o     (sums)
  );

  // gain and offset per axis
  tsc_scale u_scale (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .sum_valid_i(sum_valid),
    .sum_ready_o(sum_ready),
    .sums_i     (sums),
    .sc_valid_o (sc_valid),
    .sc_ready_i (sc_ready),
    .scaled_o   (scaled)
  );

  // pixel mapping, orientation, jump flag, result register
  tsc_map u_map (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sc_valid_i (sc_valid),
    .sc_ready_o (sc_ready),
    .scaled_i   (scaled),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .coord_x_o  (coord_x_o),
    .coord_y_o  (coord_y_o),
    .jumped_o   (jumped_o)
  );

endmodule

`default_nettype wire

@@ design/tsc_accum.sv @@
// input register, divide by the sample count and per-axis accumulation
// depends on tsc_pkg and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module tsc_accum #(
  parameter int SAMPLES = 4
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [tsc_pkg::SAMPLE_W-1:0]  x_sample_i,
  input  wire logic [tsc_pkg::SAMPLE_W-1:0]  y_sample_i,
  output logic                               sum_valid_o,
  input  wire logic                          sum_ready_i,
  output tsc_pkg::sums_t                     sums_o
);

  localparam int CNT_W  = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
  localparam int PROD_W = tsc_pkg::SAMPLE_W + tsc_pkg::RECIP_SHIFT + 1;
  // exact for 12-bit dividends and divisors up to 16
  localparam logic [tsc_pkg::RECIP_SHIFT:0] RECIP =
    (tsc_pkg::RECIP_SHIFT+1)'(((1 << tsc_pkg::RECIP_SHIFT) + SAMPLES - 1) / SAMPLES);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES - 1);

  logic                         iv_q, iv_d;
  logic [tsc_pkg::SAMPLE_W-1:0] xs_q, ys_q;
  logic [tsc_pkg::SUM_W-1:0]    sum_x_q, sum_x_d, sum_y_q, sum_y_d;
  logic [CNT_W-1:0]             cnt_q, cnt_d;
  logic                         sv_q, sv_d;
  tsc_pkg::sums_t               sums_q, sums_d;

  logic [PROD_W-1:0]            prod_x, prod_y;
  logic [tsc_pkg::SUM_W-1:0]    next_x, next_y;
  logic                         last, fire, in_xfer;

  assign prod_x = PROD_W'(xs_q) * PROD_W'(RECIP);
  assign prod_y = PROD_W'(ys_q) * PROD_W'(RECIP);
  assign next_x = sum_x_q + prod_x[tsc_pkg::RECIP_SHIFT +: tsc_pkg::SUM_W];
  assign next_y = sum_y_q + prod_y[tsc_pkg::RECIP_SHIFT +: tsc_pkg::SUM_W];

  assign last       = (cnt_q == CNT_LAST);
  // the last pair of a group needs room in the sums register
  assign fire       = iv_q && (!last || !sv_q || sum_ready_i);
  assign in_ready_o = !iv_q || fire;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_comb begin
    iv_d    = iv_q;
    sum_x_d = sum_x_q;
    sum_y_d = sum_y_q;
    cnt_d   = cnt_q;
    sv_d    = sv_q;
    sums_d  = sums_q;
    if (sv_q && sum_ready_i) begin
      sv_d = 1'b0;
    end
    if (fire) begin
      iv_d = 1'b0;
      if (last) begin
        sum_x_d      = '0;
        sum_y_d      = '0;
        cnt_d        = '0;
        sv_d         = 1'b1;
        sums_d.sum_x = next_x;
        sums_d.sum_y = next_y;
      end else begin
        sum_x_d = next_x;
        sum_y_d = next_y;
        cnt_d   = cnt_q + CNT_W'(1);
      end
    end
    if (in_xfer) begin
      iv_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iv_q    <= 1'b0;
      sum_x_q <= '0;
      sum_y_q <= '0;
      cnt_q   <= '0;
      sv_q    <= 1'b0;
    end else begin
      iv_q    <= iv_d;
      sum_x_q <= sum_x_d;
      sum_y_q <= sum_y_d;
      cnt_q   <= cnt_d;
      sv_q    <= sv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      xs_q <= x_sample_i;
      ys_q <= y_sample_i;
    end
    sums_q <= sums_d;
  end

  assign sum_valid_o = sv_q;
  assign sums_o      = sums_q;

  `TSC_ASSERT(a_group_restart, fire && last |=> (cnt_q == '0) && sv_q, "group did not restart")
  `TSC_ASSERT_NEVER(a_sums_overrun, fire && last && sv_q && !sum_ready_i, "pending sums overwritten")

endmodule

`default_nettype wire

@@ design/tsc_scale.sv @@
// gain multiply and offset add per axis, one register stage
// depends on tsc_pkg
`default_nettype none

module tsc_scale (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  tsc_pkg::cfg_t    cfg_i,
  input  wire logic        sum_valid_i,
  output logic             sum_ready_o,
  input  tsc_pkg::sums_t   sums_i,
  output logic             sc_valid_o,
  input  wire logic        sc_ready_i,
  output tsc_pkg::scaled_t scaled_o
);

  localparam int PROD_W = tsc_pkg::GAIN_W + tsc_pkg::SUM_W + 1;

  logic                       sc_v_q, sc_v_d;
  tsc_pkg::scaled_t           sc_q;
  logic signed [PROD_W-1:0]   prod_x, prod_y;
  logic                       load;

  assign prod_x = PROD_W'(cfg_i.gain_x) * $signed({1'b0, sums_i.sum_x});
  assign prod_y = PROD_W'(cfg_i.gain_y) * $signed({1'b0, sums_i.sum_y});

  assign sum_ready_o = !sc_v_q || sc_ready_i;
  assign load        = sum_valid_i && sum_ready_o;

  always_comb begin
    sc_v_d = sc_v_q;
    if (load) begin
      sc_v_d = 1'b1;
    end else if (sc_ready_i) begin
      sc_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_v_q <= 1'b0;
    end else begin
      sc_v_q <= sc_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      sc_q.acc_x     <= tsc_pkg::ACC_W'(prod_x) + tsc_pkg::ACC_W'(cfg_i.offset_x);
      sc_q.acc_y     <= tsc_pkg::ACC_W'(prod_y) + tsc_pkg::ACC_W'(cfg_i.offset_y);
      sc_q.landscape <= cfg_i.landscape;
    end
  end

  assign sc_valid_o = sc_v_q;
  assign scaled_o   = sc_q;

endmodule

`default_nettype wire

@@ design/tsc_map.sv @@
// pixel conversion, orientation rules, jump flag and result register
// depends on tsc_pkg and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module tsc_map (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       sc_valid_i,
  output logic                            sc_ready_o,
  input  tsc_pkg::scaled_t                scaled_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [tsc_pkg::PIX_W-1:0]       coord_x_o,
  output logic [tsc_pkg::PIX_W-1:0]       coord_y_o,
  output logic                            jumped_o
);

  logic                         ov_q, ov_d;
  logic [tsc_pkg::PIX_W-1:0]    coord_x_q, coord_y_q;
  logic                         jumped_q, land_q;
  logic [tsc_pkg::PIX_W-1:0]    prev_x_q, prev_y_q;

  logic signed [tsc_pkg::MIR_W-1:0] ax, ay, mir;
  logic [tsc_pkg::PIX_W-1:0]    pix_ax, pix_ay, pix_mir;
  logic [tsc_pkg::PIX_W-1:0]    cx, cy;
  logic                         jmp, load;

  assign ax  = tsc_pkg::MIR_W'(scaled_i.acc_x);
  assign ay  = tsc_pkg::MIR_W'(scaled_i.acc_y);
  assign mir = tsc_pkg::MIRROR_Q16 - ay;

  assign pix_ax  = tsc_pkg::to_pixel(ax);
  assign pix_ay  = tsc_pkg::to_pixel(ay);
  assign pix_mir = tsc_pkg::to_pixel(mir);

  always_comb begin
    if (scaled_i.landscape) begin
      cy = pix_ax;
      cx = (pix_mir >= tsc_pkg::LAND_X_LIMIT) ? '0 : pix_mir;
    end else if (pix_ax <= tsc_pkg::PIX_EDGE || pix_ay <= tsc_pkg::PIX_EDGE) begin
      cx = '0;
      cy = '0;
    end else begin
      cx = pix_ax;
      cy = pix_ay;
    end
  end

  assign jmp = (tsc_pkg::abs_diff(cx, prev_x_q) > tsc_pkg::JUMP_LIMIT) ||
               (tsc_pkg::abs_diff(cy, prev_y_q) > tsc_pkg::JUMP_LIMIT);

  assign sc_ready_o = !ov_q || out_ready_i;
  assign load       = sc_valid_i && sc_ready_o;

  always_comb begin
    ov_d = ov_q;
    if (load) begin
      ov_d = 1'b1;
    end else if (out_ready_i) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q     <= 1'b0;
      prev_x_q <= '0;
      prev_y_q <= '0;
    end else begin
      ov_q <= ov_d;
      if (load) begin
        prev_x_q <= cx;
        prev_y_q <= cy;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      coord_x_q <= cx;
      coord_y_q <= cy;
      jumped_q  <= jmp;
      land_q    <= scaled_i.landscape;
    end
  end

  assign out_valid_o = ov_q;
  assign coord_x_o   = coord_x_q;
  assign coord_y_o   = coord_y_q;
  assign jumped_o    = jumped_q;

  `TSC_ASSERT(a_land_x_range, ov_q && land_q |-> coord_x_q < tsc_pkg::LAND_X_LIMIT, "landscape x not cleared")
  `TSC_ASSERT(a_portrait_edge, ov_q && !land_q |-> ((coord_x_q == '0) == (coord_y_q == '0)) && (coord_x_q != tsc_pkg::PIX_EDGE) && (coord_y_q != tsc_pkg::PIX_EDGE), "portrait edge rule broken")

endmodule

`default_nettype wire

@@ dv/tsc_point_checker.sv @@
// checker for the touch calibration core: mirrors the config port, predicts each
// calibrated point and compares it against the output channel
// depends on tsc_pkg for widths and register indexes
`timescale 1ns / 1ps

module tsc_point_checker import tsc_pkg::*; #(
  parameter int SAMPLES = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [SAMPLE_W-1:0]   x_sample_i,
  input  logic [SAMPLE_W-1:0]   y_sample_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [PIX_W-1:0]      coord_x_i,
  input  logic [PIX_W-1:0]      coord_y_i,
  input  logic                  jumped_i,
  output int                    err_cnt_o,
  output int                    pending_o,
  output int                    checked_o
);

  localparam longint SCREEN_W_Q16 = 320 * 65536;
  localparam int     PIXEL_TOP    = 511;
  localparam int     EDGE_PIX     = 1;
  localparam int     LAND_X_CUT   = 319;
  localparam int     JUMP_PIX     = 3;
  localparam int     REPORT_MAX   = 10;

  typedef struct packed {
    logic [PIX_W-1:0] x;
    logic [PIX_W-1:0] y;
    logic             jmp;
  } point_t;

  // calibration mirror
  logic signed [GAIN_W-1:0] cal_gain_x;
  logic signed [OFFS_W-1:0] cal_offset_x;
  logic signed [GAIN_W-1:0] cal_gain_y;
  logic signed [OFFS_W-1:0] cal_offset_y;
  logic                     cal_landscape;

  // averaging and previous point
  logic [SUM_W-1:0] acc_sum_x;
  logic [SUM_W-1:0] acc_sum_y;
  int               pairs_in_group;
  logic [PIX_W-1:0] prev_x;
  logic [PIX_W-1:0] prev_y;

  point_t expected_points[$];
  int     errors;
  int     checked;

  function automatic logic [PIX_W-1:0] q16_to_pixel(input longint q);
    longint whole;
    if (q < 0) return '0;
    whole = q / 65536;
    if (whole > PIXEL_TOP) return PIX_W'(PIXEL_TOP);
    return whole[PIX_W-1:0];
  endfunction

  function automatic point_t calibrate_point(input logic [SUM_W-1:0] sx,
                                             input logic [SUM_W-1:0] sy);
    longint acc_x;
    longint acc_y;
    point_t p;
    int     dx;
    int     dy;
    acc_x = longint'(cal_gain_x) * longint'(sx) + longint'(cal_offset_x);
    acc_y = longint'(cal_gain_y) * longint'(sy) + longint'(cal_offset_y);
    if (!cal_landscape) begin
      p.x = q16_to_pixel(acc_x);
      p.y = q16_to_pixel(acc_y);
      // touch at the very edge reads as no touch
      if (p.x <= EDGE_PIX || p.y <= EDGE_PIX) begin
        p.x = '0;
        p.y = '0;
      end
    end else begin
      // axes swapped, x mirrored about the screen width
      p.y = q16_to_pixel(acc_x);
      p.x = q16_to_pixel(SCREEN_W_Q16 - acc_y);
      if (p.x >= LAND_X_CUT) p.x = '0;
    end
    dx = int'(p.x) - int'(prev_x);
    dy = int'(p.y) - int'(prev_y);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    p.jmp = (dx > JUMP_PIX) || (dy > JUMP_PIX);
    return p;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    point_t got;
    point_t want;
    if (!rst_ni) begin
      cal_gain_x     = 18'sd7668;
      cal_offset_x   = '0;
      cal_gain_y     = -18'sd10224;
      cal_offset_y   = 27'sd20971520;
      cal_landscape  = 1'b0;
      acc_sum_x      = '0;
      acc_sum_y      = '0;
      pairs_in_group = 0;
      prev_x         = '0;
      prev_y         = '0;
      errors         = 0;
      checked        = 0;
      expected_points.delete();
      err_cnt_o <= 0;
      pending_o <= 0;
      checked_o <= 0;
    end else begin
      // result side first: a point never leaves in the cycle its last pair enters
      if (out_valid_i && out_ready_i) begin
        got = '{x: coord_x_i, y: coord_y_i, jmp: jumped_i};
        if (expected_points.size() == 0) begin
          errors++;
          if (errors <= REPORT_MAX)
            $display("%0t: unexpected point x=%0d y=%0d jumped=%0d",
                     $realtime, got.x, got.y, got.jmp);
        end else begin
          want = expected_points.pop_front();
          checked++;
          if (got.x != want.x || got.y != want.y || got.jmp != want.jmp) begin
            errors++;
            if (errors <= REPORT_MAX)
              $display("%0t: point %0d expected x=%0d y=%0d jumped=%0d, got x=%0d y=%0d jumped=%0d",
                       $realtime, checked, want.x, want.y, want.jmp,
                       got.x, got.y, got.jmp);
          end
        end
      end

      if (in_valid_i && in_ready_i) begin
        acc_sum_x = acc_sum_x + SUM_W'(x_sample_i / SAMPLES);
        acc_sum_y = acc_sum_y + SUM_W'(y_sample_i / SAMPLES);
        pairs_in_group++;
        if (pairs_in_group == SAMPLES) begin
          want = calibrate_point(acc_sum_x, acc_sum_y);
          prev_x = want.x;
          prev_y = want.y;
          expected_points.push_back(want);
          acc_sum_x      = '0;
          acc_sum_y      = '0;
          pairs_in_group = 0;
        end
      end

      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_GAIN_X:    cal_gain_x    = cfg_wdata_i[GAIN_W-1:0];
          REG_OFFSET_X:  cal_offset_x  = cfg_wdata_i[OFFS_W-1:0];
          REG_GAIN_Y:    cal_gain_y    = cfg_wdata_i[GAIN_W-1:0];
          REG_OFFSET_Y:  cal_offset_y  = cfg_wdata_i[OFFS_W-1:0];
          REG_LANDSCAPE: cal_landscape = cfg_wdata_i[0];
          default: ;
        endcase
      end

      err_cnt_o <= errors;
      pending_o <= expected_points.size();
      checked_o <= checked;
    end
  end

endmodule

@@ dv/tb_touch_sample_calibrate_core.sv @@
// top of the touch calibration testbench: clock, reset, stimulus and verdict
// depends on tsc_pkg, touch_sample_calibrate_core and tsc_point_checker
`timescale 1ns / 1ps

module tb_touch_sample_calibrate_core;
  import tsc_pkg::*;

  localparam int SAMPLES        = 4;
  localparam int NUM_REGS       = 5;
  localparam int ADC_MAX        = 4095;
  localparam int GROUPS_PER_CAL = 16;
  // settling margin behind the sums, scale and result registers
  localparam int DRAIN_CYCLES   = 8;
  localparam int HOLD_CYCLES    = 120;
  localparam int CYCLE_LIMIT    = 200000;

  localparam int GAIN_MIN = -131072;
  localparam int GAIN_MAX = 131071;
  localparam int OFFS_MIN = -67108864;
  localparam int OFFS_MAX = 67108863;

  // reset calibration of the block
  localparam int DEF_GAIN_X   = 7668;
  localparam int DEF_OFFSET_X = 0;
  localparam int DEF_GAIN_Y   = -10224;
  localparam int DEF_OFFSET_Y = 20971520;

  typedef enum int {
    CAL_DEFAULT,
    CAL_EXTREME_POS,
    CAL_EXTREME_NEG,
    CAL_PLAUSIBLE,
    CAL_RANDOM
  } cal_kind_e;

  typedef enum int {
    MODE_STEADY,
    MODE_RANDOM,
    MODE_EXTREME,
    MODE_NEW_TOUCH
  } sample_mode_e;

  // dut stimulus, all known from time zero
  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i  = 1'b0;
  logic [SAMPLE_W-1:0]   x_sample_i  = '0;
  logic [SAMPLE_W-1:0]   y_sample_i  = '0;
  logic                  out_ready_i = 1'b0;

  logic                  in_ready_o;
  logic                  out_valid_o;
  logic [PIX_W-1:0]      coord_x_o;
  logic [PIX_W-1:0]      coord_y_o;
  logic                  jumped_o;

  // from the checker
  int err_cnt;
  int points_pending;
  int points_checked;

  // knobs and bookkeeping
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req      = 0;
  int pairs_sent    = 0;
  int settings_done = 0;
  int touch_x       = 2048;
  int touch_y       = 2048;
  int cycle_cnt     = 0;

  touch_sample_calibrate_core #(
    .SAMPLES(SAMPLES)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .x_sample_i (x_sample_i),
    .y_sample_i (y_sample_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .coord_x_o  (coord_x_o),
    .coord_y_o  (coord_y_o),
    .jumped_o   (jumped_o)
  );

  tsc_point_checker #(
    .SAMPLES(SAMPLES)
  ) u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_i (in_ready_o),
    .x_sample_i (x_sample_i),
    .y_sample_i (y_sample_i),
    .out_valid_i(out_valid_o),
    .out_ready_i(out_ready_i),
    .coord_x_i  (coord_x_o),
    .coord_y_i  (coord_y_o),
    .jumped_i   (jumped_o),
    .err_cnt_o  (err_cnt),
    .pending_o  (points_pending),
    .checked_o  (points_checked)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog on total run length
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d points still outstanding",
               cycle_cnt, points_pending);
      $display("FAILURE");
      $finish;
    end
  end

  // receiver: random stalls, or a long hold-off when the stimulus asks for one
  // the hold-off is counted here so the sender keeps offering pairs meanwhile
  always @(posedge clk_i) begin
    int hold_seen;
    int hold_left;
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // one pair on the input channel; valid stays up across back-to-back transfers
  task automatic send_pair(input int xs, input int ys);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    x_sample_i <= SAMPLE_W'(xs);
    y_sample_i <= SAMPLE_W'(ys);
    do @(posedge clk_i); while (!in_ready_o);
    pairs_sent++;
  endtask

  // stop offering, let every outstanding point arrive, then let open pairs settle
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (points_pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // write all five registers, gains and landscape with junk above their width,
  // then poke the unused indexes, which the block must ignore
  task automatic program_cal(input int gx, input int ox, input int gy, input int oy,
                             input bit land);
    logic [CFG_DATA_W-1:0] junk;
    logic [CFG_DATA_W-1:0] regval [NUM_REGS];
    junk = CFG_DATA_W'($urandom);
    regval[REG_GAIN_X]    = {junk[CFG_DATA_W-1:GAIN_W], gx[GAIN_W-1:0]};
    regval[REG_OFFSET_X]  = ox[OFFS_W-1:0];
    regval[REG_GAIN_Y]    = {~junk[CFG_DATA_W-1:GAIN_W], gy[GAIN_W-1:0]};
    regval[REG_OFFSET_Y]  = oy[OFFS_W-1:0];
    regval[REG_LANDSCAPE] = {junk[CFG_DATA_W-1:1], land};
    for (int i = 0; i < 2**CFG_IDX_W; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= CFG_IDX_W'(i);
      cfg_wdata_i <= (i < NUM_REGS) ? regval[i] : CFG_DATA_W'($urandom);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    settings_done++;
  endtask

  task automatic calibrate(input cal_kind_e kind);
    int gx;
    int ox;
    int gy;
    int oy;
    bit land;
    land = 1'($urandom_range(1));
    case (kind)
      CAL_DEFAULT: begin
        gx = DEF_GAIN_X;
        ox = DEF_OFFSET_X;
        gy = DEF_GAIN_Y;
        oy = DEF_OFFSET_Y;
      end
      CAL_EXTREME_POS: begin
        gx = GAIN_MAX;
        ox = OFFS_MIN;
        gy = GAIN_MIN;
        oy = OFFS_MAX;
      end
      CAL_EXTREME_NEG: begin
        gx = GAIN_MIN;
        ox = OFFS_MAX;
        gy = GAIN_MAX;
        oy = OFFS_MIN;
      end
      CAL_PLAUSIBLE: begin
        // gains and offsets that keep most points on screen
        gx = int'($urandom_range(0, 20000));
        gy = int'($urandom_range(0, 20000));
        if ($urandom_range(1)) gx = -gx;
        if ($urandom_range(1)) gy = -gy;
        ox = int'($urandom_range(0, 650 * 65536)) - 50 * 65536;
        oy = int'($urandom_range(0, 650 * 65536)) - 50 * 65536;
      end
      default: begin
        gx = int'($urandom_range(0, GAIN_MAX - GAIN_MIN)) + GAIN_MIN;
        gy = int'($urandom_range(0, GAIN_MAX - GAIN_MIN)) + GAIN_MIN;
        ox = int'($urandom_range(0, OFFS_MAX - OFFS_MIN)) + OFFS_MIN;
        oy = int'($urandom_range(0, OFFS_MAX - OFFS_MIN)) + OFFS_MIN;
      end
    endcase
    program_cal(gx, ox, gy, oy, land);
  endtask

  function automatic int clamp_adc(input int v);
    if (v < 0) return 0;
    if (v > ADC_MAX) return ADC_MAX;
    return v;
  endfunction

  // one averaging group; steady groups hover around the current touch so the
  // jump flag is seen low as well as high
  task automatic send_group(input sample_mode_e mode);
    int xs;
    int ys;
    if (mode == MODE_NEW_TOUCH) begin
      touch_x = $urandom_range(0, ADC_MAX);
      touch_y = $urandom_range(0, ADC_MAX);
    end
    for (int n = 0; n < SAMPLES; n++) begin
      case (mode)
        MODE_RANDOM: begin
          xs = $urandom_range(0, ADC_MAX);
          ys = $urandom_range(0, ADC_MAX);
        end
        MODE_EXTREME: begin
          xs = $urandom_range(1) ? ADC_MAX : 0;
          ys = $urandom_range(1) ? ADC_MAX : 0;
        end
        default: begin
          xs = clamp_adc(touch_x + int'($urandom_range(0, 15)) - 8);
          ys = clamp_adc(touch_y + int'($urandom_range(0, 15)) - 8);
        end
      endcase
      send_pair(xs, ys);
    end
  endtask

  task automatic send_fixed_group(input int xs, input int ys);
    for (int n = 0; n < SAMPLES; n++) send_pair(xs, ys);
  endtask

  initial begin
    int r;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset calibration in portrait:
    // no touch, full-scale x (first a jump, then a repeat with no jump),
    // alternating bit patterns
    send_fixed_group(0, 0);
    send_fixed_group(ADC_MAX, 0);
    send_fixed_group(ADC_MAX, 0);
    send_fixed_group(12'hAAA, 12'h555);

    // directed landscape: mirrored x past the right edge, and mirrored x at zero
    wait_drained();
    program_cal(DEF_GAIN_X, DEF_OFFSET_X, DEF_GAIN_Y, DEF_OFFSET_Y, 1'b1);
    send_fixed_group(0, ADC_MAX);
    send_fixed_group(ADC_MAX, 0);

    // random part: three idle profiles, four calibrations each
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 6;
          recv_idle_pct = 55;
        end
        1: begin
          send_idle_pct = 55;
          recv_idle_pct = 6;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int k = 0; k < 4; k++) begin
        wait_drained();
        calibrate(cal_kind_e'((phase * 4 + k) % 5));
        // back-pressure: receiver holds off while the sender streams
        if (phase == 0 && k == 1) begin
          send_idle_pct = 0;
          hold_req <= hold_req + 1;
        end
        for (int g = 0; g < GROUPS_PER_CAL; g++) begin
          // sender pause mid-setting until every point is out
          if (phase == 1 && k == 2 && g == GROUPS_PER_CAL / 2) wait_drained();
          r = $urandom_range(0, 5);
          send_group((r < 3) ? MODE_STEADY : sample_mode_e'(r - 2));
        end
        if (phase == 0 && k == 1) send_idle_pct = 6;
      end
    end

    wait_drained();
    $display("covered %0d sample pairs and %0d checked points over %0d calibration settings",
             pairs_sent, points_checked, settings_done);
    $display("portrait and landscape, saturating gains and offsets, stalls on both channels");
    if (err_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
